// File: rtl/stride_descriptor_rank_compressor_macros.svh
// Assertion helpers shared by the checking code of the rank compressor.
`ifndef STRIDE_DESCRIPTOR_RANK_COMPRESSOR_MACROS_SVH
`define STRIDE_DESCRIPTOR_RANK_COMPRESSOR_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SDRC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SDRC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/sdrc_pkg.sv
// ----------------------------------------------------------------------------
// sdrc_pkg
// Types, sizes and helpers shared by the stride descriptor rank compressor.
// ----------------------------------------------------------------------------
package sdrc_pkg;

	localparam int STORE_WORDS = 64;
	localparam int MAX_DEPTH   = 4;
	localparam int AW          = $clog2(STORE_WORDS) + 2;
	localparam int DW          = 4;
	localparam int JW          = 5;
	localparam int POS_SLOTS   = STORE_WORDS / 4;
	localparam int PIW         = $clog2(POS_SLOTS);
	localparam int QDEPTH      = 2;
	localparam int NEW_WORDS   = 4;

	localparam logic [31:0] WORD_M1    = 32'hFFFF_FFFF;
	localparam logic [31:0] FOLD_ITERS = 32'd2;

	typedef logic [31:0]   word_t;
	typedef logic [AW-1:0] addr_t;
	typedef logic [DW-1:0] depth_t;

	typedef enum logic {
		OP_ADD  = 1'b0,
		OP_DUMP = 1'b1
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [30:0] rank;
	} item_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_INIT,
		S_WALK,
		S_EXT,
		S_MUL,
		S_EXTCHK,
		S_EXTWR,
		S_APP,
		S_FSTART,
		S_TRY,
		S_CMP,
		S_EQST,
		S_SHIFT,
		S_EQWR,
		S_DPRD,
		S_DPCHK,
		S_DPWR,
		S_NEXT,
		S_RESULT,
		S_DUMP
	} state_t;

	// negated depth word to a depth, clamped to 1..MAX_DEPTH
	function automatic depth_t depth_of(word_t w);
		word_t d;
		d = 32'd0 - w;
		if (d < 32'd1)
			return depth_t'(1);
		else if (d > 32'(MAX_DEPTH))
			return depth_t'(MAX_DEPTH);
		else
			return d[DW-1:0];
	endfunction

endpackage

// File: rtl/sdrc_req_if.sv
// ----------------------------------------------------------------------------
// sdrc_req_if
// Request channel: opcode and rank with valid/ready.
// ----------------------------------------------------------------------------
interface sdrc_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [30:0] rank_value;

	modport source (output valid, output opcode, output rank_value, input ready);
	modport sink   (input valid, input opcode, input rank_value, output ready);
endinterface

// File: rtl/sdrc_rsp_if.sv
// ----------------------------------------------------------------------------
// sdrc_rsp_if
// Response channel: list word, member count, status and last flag.
// ----------------------------------------------------------------------------
interface sdrc_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] list_word;
	logic [30:0]        member_count;
	logic               status;
	logic               last_flag;

	modport source (output valid, output list_word, output member_count,
		output status, output last_flag, input ready);
	modport sink   (input valid, input list_word, input member_count,
		input status, input last_flag, output ready);
endinterface

// File: rtl/sdrc_front.sv
// ----------------------------------------------------------------------------
// sdrc_front
// Takes request transfers, classifies the opcode and queues them for the back end.
// ----------------------------------------------------------------------------
module sdrc_front
	import sdrc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	sdrc_req_if.sink req,
	output item_t q_item,
	output logic  q_valid,
	input  logic  q_pop
);

	localparam int QPW = $clog2(QDEPTH);

	item_t              slot_q [QDEPTH];
	logic [QPW-1:0]     wptr_q;
	logic [QPW-1:0]     rptr_q;
	logic [QPW:0]       count_q;
	logic               push;

	assign req.ready = (count_q != (QPW+1)'(QDEPTH));
	assign push      = req.valid && req.ready;
	assign q_valid   = (count_q != '0);
	assign q_item    = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q].op   <= req.opcode ? OP_DUMP : OP_ADD;
			slot_q[wptr_q].rank <= req.rank_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= (wptr_q == QPW'(QDEPTH-1)) ? '0 : wptr_q + 1'b1;
			if (q_pop && q_valid)
				rptr_q <= (rptr_q == QPW'(QDEPTH-1)) ? '0 : rptr_q + 1'b1;
			count_q <= count_q + (QPW+1)'(push) - (QPW+1)'(q_pop && q_valid);
		end
	end

endmodule

// File: rtl/sdrc_back.sv
// ----------------------------------------------------------------------------
// sdrc_back
// Sequencer over the descriptor store: add, extend, append, fold and dump.
// ----------------------------------------------------------------------------
module sdrc_back
	import sdrc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  item_t q_item,
	input  logic  q_valid,
	output logic  q_pop,
	sdrc_rsp_if.source rsp
);

	state_t       state_q, state_d;

	word_t        mem [STORE_WORDS];
	word_t        rdata_q;
	addr_t        raddr;
	logic         we;
	addr_t        waddr;
	word_t        wdata;

	addr_t        pos_q [POS_SLOTS];
	depth_t       dep_q [POS_SLOTS];

	word_t        rank_q;
	logic [1:0]   ph_q;
	logic [JW-1:0] j_q;
	logic [PIW-1:0] w_q;
	logic [PIW-1:0] i_q;
	addr_t        p_q;
	addr_t        last_q;
	depth_t       ldep_q;
	logic         lm1_q;
	addr_t        prev_q;
	depth_t       pdep_q;
	logic         fold_q;
	logic         eq_q;
	word_t        w0_q, w1_q, w2_q, w3_q;
	word_t        prod_q;
	word_t        nx_q;
	word_t        a_q;
	word_t        diff_q;
	addr_t        s_q;
	addr_t        k_q;
	logic [5:0]   total_q;
	logic [6:0]   used_q;
	logic [30:0]  ranks_q;
	logic         st_q;

	logic         ovld_q;
	word_t        oword_q;
	logic         olast_q;
	logic         ost_q;

	logic         out_free;
	logic         load_out;
	word_t        load_word;
	logic         load_last;
	depth_t       wdep;
	logic         walk_end;
	word_t        nx;
	logic [JW-1:0] jend;
	addr_t        nwords;
	addr_t        cmp_off;
	addr_t        try_prev;
	depth_t       try_dep;
	logic         app_full;

	assign out_free = !ovld_q || rsp.ready;
	assign wdep     = depth_of(rdata_q);
	assign walk_end = ({2'b00, w_q} == total_q - 6'd1);
	assign nx       = w0_q + prod_q;
	assign jend     = {ldep_q, 1'b1};
	assign cmp_off  = eq_q ? addr_t'(0) : addr_t'(2);
	assign try_prev = pos_q[i_q];
	assign try_dep  = dep_q[i_q];
	assign app_full = ({1'b0, used_q} + 8'(NEW_WORDS)) > 8'(STORE_WORDS);

	always_comb begin
		if (used_q == 7'd0)
			nwords = addr_t'(1);
		else if (AW'(used_q) > addr_t'(STORE_WORDS))
			nwords = addr_t'(STORE_WORDS);
		else
			nwords = AW'(used_q);
	end

	// store: one write port, one registered read port; beyond the store reads zero
	always_ff @(posedge clk) begin
		if (we && (waddr < addr_t'(STORE_WORDS)))
			mem[waddr[$clog2(STORE_WORDS)-1:0]] <= wdata;
		rdata_q <= (raddr < addr_t'(STORE_WORDS)) ?
			mem[raddr[$clog2(STORE_WORDS)-1:0]] : '0;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_WALK && ph_q == 2'd1) begin
			pos_q[w_q] <= p_q;
			dep_q[w_q] <= wdep;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		raddr     = '0;
		we        = 1'b0;
		waddr     = '0;
		wdata     = '0;
		q_pop     = 1'b0;
		load_out  = 1'b0;
		load_word = '0;
		load_last = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (q_valid && out_free) begin
					q_pop = 1'b1;
					if (q_item.op == OP_DUMP)
						state_d = S_DUMP;
					else if (total_q == 6'd0)
						state_d = S_INIT;
					else
						state_d = S_WALK;
				end
			end
			S_INIT, S_APP: begin
				we    = 1'b1;
				waddr = (state_q == S_INIT) ? addr_t'(1) + AW'(j_q) : AW'(used_q) + AW'(j_q);
				case (j_q[1:0])
					2'd0:    wdata = WORD_M1;
					2'd1:    wdata = rank_q;
					2'd2:    wdata = 32'd1;
					default: wdata = 32'd0;
				endcase
				if (j_q == JW'(NEW_WORDS-1))
					state_d = (state_q == S_INIT) ? S_RESULT : S_FSTART;
			end
			S_WALK: begin
				raddr = p_q;
				if (ph_q == 2'd1 && walk_end)
					state_d = fold_q ? S_TRY : S_EXT;
			end
			S_EXT: begin
				raddr = last_q + addr_t'(1) + AW'(j_q);
				if (ph_q == 2'd1 && j_q == JW'(2))
					state_d = S_MUL;
			end
			S_MUL: state_d = fold_q ? S_DPCHK : S_EXTCHK;
			S_EXTCHK: begin
				if (lm1_q && (nx == rank_q || nx == w0_q))
					state_d = S_EXTWR;
				else if (app_full)
					state_d = S_RESULT;
				else
					state_d = S_APP;
			end
			S_EXTWR: begin
				we = 1'b1;
				if (j_q == '0) begin
					waddr = last_q + addr_t'(2);
					wdata = w1_q + 32'd1;
				end else begin
					waddr = last_q + addr_t'(3);
					wdata = w2_q + (rank_q - nx_q);
					state_d = S_FSTART;
				end
			end
			S_FSTART: state_d = (total_q < 6'd2) ? S_RESULT : S_WALK;
			S_TRY: begin
				if (try_dep == ldep_q)
					state_d = (ldep_q >= DW'(MAX_DEPTH)) ? S_NEXT : S_CMP;
				else if (try_dep == ldep_q + depth_t'(1))
					state_d = S_DPRD;
				else
					state_d = S_NEXT;
			end
			S_CMP: begin
				if (ph_q == 2'd0)
					raddr = last_q + AW'(j_q);
				else
					raddr = prev_q + cmp_off + AW'(j_q);
				if (ph_q == 2'd2) begin
					if (rdata_q != a_q)
						state_d = S_NEXT;
					else if (j_q == jend)
						state_d = eq_q ? S_EQST : S_DPWR;
				end
			end
			S_EQST: begin
				raddr = (ph_q == 2'd0) ? last_q + addr_t'(1) : prev_q + addr_t'(1);
				if (ph_q == 2'd2)
					state_d = S_SHIFT;
			end
			S_SHIFT: begin
				raddr = s_q;
				if (ph_q == 2'd0) begin
					if (s_q <= prev_q + addr_t'(1))
						state_d = S_EQWR;
				end else begin
					we    = 1'b1;
					waddr = s_q + addr_t'(2);
					wdata = rdata_q;
				end
			end
			S_EQWR: begin
				we = 1'b1;
				case (j_q[1:0])
					2'd0: begin
						waddr = prev_q;
						wdata = 32'd0 - 32'(pdep_q) - 32'd1;
					end
					2'd1: begin
						waddr = prev_q + addr_t'(2);
						wdata = FOLD_ITERS;
					end
					default: begin
						waddr = prev_q + addr_t'(3);
						wdata = diff_q;
					end
				endcase
				if (j_q == JW'(2))
					state_d = S_FSTART;
			end
			S_DPRD: begin
				raddr = (j_q == JW'(3)) ? last_q + addr_t'(1) : prev_q + addr_t'(1) + AW'(j_q);
				if (ph_q == 2'd1 && j_q == JW'(3))
					state_d = S_MUL;
			end
			S_DPCHK: state_d = (nx != w3_q) ? S_NEXT : S_CMP;
			S_DPWR: begin
				we      = 1'b1;
				waddr   = prev_q + addr_t'(2);
				wdata   = w1_q + 32'd1;
				state_d = S_FSTART;
			end
			S_NEXT: state_d = (i_q == '0) ? S_RESULT : S_TRY;
			S_RESULT: begin
				if (out_free) begin
					load_out  = 1'b1;
					load_word = '0;
					load_last = 1'b1;
					state_d   = S_IDLE;
				end
			end
			S_DUMP: begin
				raddr = k_q;
				if (ph_q == 2'd1 && out_free) begin
					load_out  = 1'b1;
					load_word = (k_q == '0) ? 32'(total_q) : rdata_q;
					load_last = (k_q == nwords - addr_t'(1));
					if (load_last)
						state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q  <= '0;
			ph_q    <= '0;
			j_q     <= '0;
			w_q     <= '0;
			i_q     <= '0;
			p_q     <= '0;
			last_q  <= '0;
			ldep_q  <= '0;
			lm1_q   <= 1'b0;
			prev_q  <= '0;
			pdep_q  <= '0;
			fold_q  <= 1'b0;
			eq_q    <= 1'b0;
			w0_q    <= '0;
			w1_q    <= '0;
			w2_q    <= '0;
			w3_q    <= '0;
			prod_q  <= '0;
			nx_q    <= '0;
			a_q     <= '0;
			diff_q  <= '0;
			s_q     <= '0;
			k_q     <= '0;
			total_q <= '0;
			used_q  <= 7'd1;
			ranks_q <= '0;
			st_q    <= 1'b0;
			ovld_q  <= 1'b0;
			oword_q <= '0;
			olast_q <= 1'b0;
			ost_q   <= 1'b0;
		end else begin
			if (rsp.ready)
				ovld_q <= 1'b0;
			if (load_out) begin
				ovld_q  <= 1'b1;
				oword_q <= load_word;
				olast_q <= load_last;
				ost_q   <= (state_q == S_RESULT) ? st_q : 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						rank_q <= {1'b0, q_item.rank};
						st_q   <= 1'b0;
						ph_q   <= '0;
						j_q    <= '0;
						w_q    <= '0;
						k_q    <= '0;
						p_q    <= addr_t'(1);
						fold_q <= 1'b0;
					end
				end
				S_INIT: begin
					j_q <= j_q + 1'b1;
					if (j_q == JW'(NEW_WORDS-1)) begin
						total_q <= 6'd1;
						used_q  <= 7'd5;
						ranks_q <= ranks_q + 31'd1;
					end
				end
				S_WALK: begin
					if (ph_q == 2'd0) begin
						ph_q <= 2'd1;
					end else begin
						ph_q <= 2'd0;
						if (walk_end) begin
							last_q <= p_q;
							ldep_q <= wdep;
							lm1_q  <= (rdata_q == WORD_M1);
							j_q    <= '0;
							i_q    <= PIW'(total_q - 6'd2);
						end else begin
							p_q <= p_q + AW'({wdep, 1'b0}) + addr_t'(2);
							w_q <= w_q + 1'b1;
						end
					end
				end
				S_EXT, S_DPRD: begin
					if (ph_q == 2'd0) begin
						ph_q <= 2'd1;
					end else begin
						ph_q <= 2'd0;
						j_q  <= j_q + 1'b1;
						case (j_q[1:0])
							2'd0:    w0_q <= rdata_q;
							2'd1:    w1_q <= rdata_q;
							2'd2:    w2_q <= rdata_q;
							default: w3_q <= rdata_q;
						endcase
					end
				end
				S_MUL: prod_q <= w1_q * w2_q;
				S_EXTCHK: begin
					nx_q <= nx;
					j_q  <= '0;
					if (!(lm1_q && (nx == rank_q || nx == w0_q)) && app_full)
						st_q <= 1'b1;
				end
				S_EXTWR: begin
					j_q <= j_q + 1'b1;
					if (j_q != '0)
						ranks_q <= ranks_q + 31'd1;
				end
				S_APP: begin
					j_q <= j_q + 1'b1;
					if (j_q == JW'(NEW_WORDS-1)) begin
						total_q <= total_q + 6'd1;
						used_q  <= used_q + 7'(NEW_WORDS);
						ranks_q <= ranks_q + 31'd1;
					end
				end
				S_FSTART: begin
					fold_q <= 1'b1;
					w_q    <= '0;
					p_q    <= addr_t'(1);
					ph_q   <= '0;
				end
				S_TRY: begin
					prev_q <= try_prev;
					pdep_q <= try_dep;
					ph_q   <= '0;
					eq_q   <= (try_dep == ldep_q);
					j_q    <= (try_dep == ldep_q) ? JW'(2) : '0;
				end
				S_CMP: begin
					case (ph_q)
						2'd0: ph_q <= 2'd1;
						2'd1: begin
							a_q  <= rdata_q;
							ph_q <= 2'd2;
						end
						default: begin
							ph_q <= 2'd0;
							j_q  <= j_q + 1'b1;
						end
					endcase
				end
				S_EQST: begin
					case (ph_q)
						2'd0: ph_q <= 2'd1;
						2'd1: begin
							a_q  <= rdata_q;
							ph_q <= 2'd2;
						end
						default: begin
							diff_q <= a_q - rdata_q;
							s_q    <= last_q - addr_t'(1);
							ph_q   <= 2'd0;
						end
					endcase
				end
				S_SHIFT: begin
					if (ph_q == 2'd0) begin
						if (s_q <= prev_q + addr_t'(1))
							j_q <= '0;
						else
							ph_q <= 2'd1;
					end else begin
						ph_q <= 2'd0;
						s_q  <= s_q - addr_t'(1);
					end
				end
				S_EQWR: begin
					j_q <= j_q + 1'b1;
					if (j_q == JW'(2)) begin
						total_q <= total_q - 6'd1;
						used_q  <= 7'(last_q + addr_t'(2));
					end
				end
				S_DPCHK: begin
					j_q  <= JW'(2);
					ph_q <= '0;
				end
				S_DPWR: begin
					total_q <= total_q - 6'd1;
					used_q  <= 7'(last_q);
				end
				S_NEXT: i_q <= i_q - 1'b1;
				S_DUMP: begin
					if (ph_q == 2'd0) begin
						ph_q <= 2'd1;
					end else if (out_free) begin
						ph_q <= 2'd0;
						k_q  <= k_q + addr_t'(1);
					end
				end
				default: ;
			endcase
		end
	end

	assign rsp.valid        = ovld_q;
	assign rsp.list_word    = oword_q;
	assign rsp.member_count = ranks_q;
	assign rsp.status       = ost_q;
	assign rsp.last_flag    = olast_q;

endmodule

// File: rtl/stride_descriptor_rank_compressor.sv
// ----------------------------------------------------------------------------
// stride_descriptor_rank_compressor
// Keeps ascending ranks as a packed list of nested strided descriptors.
// ----------------------------------------------------------------------------
// Requests go into a two-entry queue; a sequencer works on one item at a time
// over a descriptor store with one write port and one registered read port,
// so each store read waits on the registered read data. An add walks the list
// to its last descriptor, then extends it or appends a new one, then folds:
// every fold pass re-walks the list and tries each earlier descriptor, word by
// word, and moves the words in between on a depth raise. A dump gives one
// transfer per list word, held while the receiver stalls, the descriptor count
// first and the last flagged. The member count field always shows the ranks
// held after the item.
`include "stride_descriptor_rank_compressor_macros.svh"

module stride_descriptor_rank_compressor
	import sdrc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	sdrc_req_if.sink   req,
	sdrc_rsp_if.source rsp
);

	item_t q_item;
	logic  q_valid;
	logic  q_pop;

	sdrc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.q_item  (q_item),
		.q_valid (q_valid),
		.q_pop   (q_pop)
	);

	sdrc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_item  (q_item),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.rsp     (rsp)
	);

	`SDRC_ASSERT_NOW(a_pop_needs_item, q_pop, q_valid, "queue popped while empty")
	`SDRC_ASSERT_NOW(a_pop_out_free, q_pop, !rsp.valid || rsp.ready, "item started on busy output")
	`SDRC_ASSERT_NEXT(a_queue_holds, q_valid && !q_pop, q_valid, "queued item lost")

endmodule

// File: sim/stride_descriptor_rank_compressor_tb.sv
// ----------------------------------------------------------------------------
// stride_descriptor_rank_compressor_tb
// Drives ranks and dumps into the rank compressor and checks every transfer
// against a behavioral copy of the descriptor list kept in the testbench.
// ----------------------------------------------------------------------------
module stride_descriptor_rank_compressor_tb;
	import sdrc_pkg::*;

	typedef struct packed {
		logic [31:0] word;
		logic [30:0] count;
		logic        status;
		logic        last;
	} rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	sdrc_req_if req ();
	sdrc_rsp_if rsp ();

	stride_descriptor_rank_compressor u_dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source)
	);

	always #5 clk = ~clk;

	// list model
	logic [31:0] list_mem [STORE_WORDS];
	logic [31:0] desc_total;
	logic [31:0] used_words;
	logic [30:0] held;
	rsp_t        expect_q [$];
	int          errors = 0;
	int          cycles = 0;
	int          hold_off = 0;
	bit          rx_quiet = 0;
	logic [30:0] rank_cursor;

	function automatic logic [31:0] rd(logic [31:0] i);
		return (i < STORE_WORDS) ? list_mem[i] : 32'd0;
	endfunction

	function automatic void wr(logic [31:0] i, logic [31:0] v);
		if (i < STORE_WORDS)
			list_mem[i] = v;
	endfunction

	function automatic logic [31:0] depth_at(logic [31:0] p);
		logic [31:0] d;
		d = 32'd0 - rd(p);
		if (d < 1) d = 1;
		if (d > MAX_DEPTH) d = MAX_DEPTH;
		return d;
	endfunction

	function automatic void set_total(logic [31:0] t);
		desc_total = t & 32'h3F;
		wr(0, desc_total);
	endfunction

	function automatic bit try_fold(logic [31:0] last, logic [31:0] prev);
		logic [31:0] dl, dp, st, i;
		dl = depth_at(last);
		dp = depth_at(prev);
		if (dp == dl) begin
			if (dl >= MAX_DEPTH) return 0;
			for (int k = 0; k < dl; k++)
				if (rd(last+2+2*k) != rd(prev+2+2*k) || rd(last+3+2*k) != rd(prev+3+2*k))
					return 0;
			st = rd(last + 1);
			for (i = last - 1; i > prev + 1; i--)
				wr(i + 2, rd(i));
			wr(prev, rd(prev) - 1);
			wr(prev + 2, 32'd2);
			wr(prev + 3, st - rd(prev + 1));
			set_total(desc_total - 1);
			used_words = last + 2;
			return 1;
		end
		if (dp == dl + 1) begin
			if (rd(prev+1) + rd(prev+2) * rd(prev+3) != rd(last+1)) return 0;
			for (int k = 0; k < dl; k++)
				if (rd(last+2+2*k) != rd(prev+4+2*k) || rd(last+3+2*k) != rd(prev+5+2*k))
					return 0;
			wr(prev + 2, rd(prev + 2) + 1);
			set_total(desc_total - 1);
			used_words = last;
			return 1;
		end
		return 0;
	endfunction

	function automatic bit fold_pass();
		logic [31:0] pos [STORE_WORDS];
		logic [31:0] p;
		int n;
		n = desc_total;
		p = 1;
		if (n < 2) return 0;
		for (int i = 0; i < n; i++) begin
			pos[i] = p;
			p += 2 * (depth_at(p) + 1);
		end
		for (int i = n - 2; i >= 0; i--)
			if (try_fold(pos[n-1], pos[i]))
				return 1;
		return 0;
	endfunction

	function automatic bit add_rank(logic [30:0] r);
		logic [31:0] p, last, st, it, sd, nx, rank;
		rank = {1'b0, r};
		p = 1;
		last = 1;
		if (desc_total == 0) begin
			wr(1, WORD_M1); wr(2, rank); wr(3, 1); wr(4, 0);
			set_total(1);
			used_words = 5;
			held++;
			return 0;
		end
		for (int i = 0; i < desc_total; i++) begin
			last = p;
			p += 2 * (depth_at(p) + 1);
		end
		if (rd(last) == WORD_M1) begin
			st = rd(last + 1); it = rd(last + 2); sd = rd(last + 3);
			nx = st + it * sd;
			if (nx == rank || nx == st) begin
				wr(last + 2, it + 1);
				wr(last + 3, sd + (rank - nx));
				held++;
				while (fold_pass());
				return 0;
			end
		end
		if (p + NEW_WORDS > STORE_WORDS) return 1;
		wr(p, WORD_M1); wr(p + 1, rank); wr(p + 2, 1); wr(p + 3, 0);
		set_total(desc_total + 1);
		used_words = p + 4;
		held++;
		while (fold_pass());
		return 0;
	endfunction

	function automatic void predict(op_t op, logic [30:0] r);
		bit full;
		int n;
		rsp_t e;
		if (op == OP_ADD) begin
			full = add_rank(r);
			e = '{32'd0, held, full, 1'b1};
			expect_q.insert(expect_q.size(), e);
		end else begin
			n = used_words;
			if (n < 1) n = 1;
			if (n > STORE_WORDS) n = STORE_WORDS;
			for (int k = 0; k < n; k++) begin
				e = '{rd(k), held, 1'b0, k + 1 == n};
				expect_q.insert(expect_q.size(), e);
			end
		end
	endfunction

	task automatic send(op_t op, logic [30:0] r);
		req.valid <= 1'b1;
		req.opcode <= op;
		req.rank_value <= r;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		predict(op, r);
		@(negedge clk);
		// bursts with random gaps
		if ($urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	task automatic add(logic [30:0] r);
		send(OP_ADD, r);
	endtask

	task automatic dump();
		send(OP_DUMP, 31'($urandom));
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (expect_q.size() != 0) @(negedge clk);
		repeat (120) @(negedge clk);
	endtask

	task automatic test_empty_and_extremes();
		dump();
		add(31'd0);
		add(31'd0);
		add(31'h7FFF_FFFF);
		dump();
	endtask

	task automatic test_strided_runs();
		// two equal runs fold to depth 2, a third bumps the outer count
		for (int b = 0; b < 3; b++)
			for (int i = 0; i < 3; i++)
				add(31'(31'h7FFF_F000 + b * 100 + i * 5));
		dump();
	endtask

	task automatic test_max_depth();
		// nesting beyond the depth limit must stop folding
		for (int a = 0; a < 2; a++)
			for (int b = 0; b < 2; b++)
				for (int c = 0; c < 2; c++)
					for (int d = 0; d < 2; d++)
						for (int e = 0; e < 2; e++)
							add(31'(31'h1000 + a*4096 + b*512 + c*64 + d*8 + e));
		dump();
	endtask

	task automatic test_overflow_stall();
		// receiver quiet while the sender keeps offering
		hold_off = 400;
		for (int i = 0; i < 20; i++)
			add(31'(31'h4000_0000 + i * i * 7 + i));
		dump();
	endtask

	task automatic test_random();
		logic [30:0] base, stride;
		int cnt;
		int total;
		total = 0;
		while (total < 360) begin
			if ($urandom_range(0, 9) == 0) begin
				dump();
				total++;
			end else if ($urandom_range(0, 9) == 0) begin
				add(31'($urandom));
				total++;
			end else begin
				base = 31'(rank_cursor + $urandom_range(1, 50));
				stride = 31'($urandom_range(1, 4) * (1 << $urandom_range(0, 3)));
				cnt = $urandom_range(1, 4);
				for (int i = 0; i < cnt; i++)
					add(31'(base + i * stride));
				rank_cursor = 31'(base + cnt * stride + $urandom_range(0, 3) * 16);
				total += cnt;
			end
			// now and then a dump, then wait until every expected transfer is in
			if ($urandom_range(0, 60) == 0) begin
				dump();
				drain();
				total++;
			end
		end
		dump();
	endtask

	// receiver stall pattern plus long hold-off
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			rsp.ready <= 1'b0;
		end else if (rx_quiet)
			rsp.ready <= 1'b1;
		else
			rsp.ready <= ($urandom_range(0, 2) != 0);
		if ($urandom_range(0, 99) == 0)
			rx_quiet <= ~rx_quiet;
	end

	always @(posedge clk) begin
		rsp_t want;
		cycles <= cycles + 1;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expect_q.size() == 0) begin
				$display("%0t: unexpected transfer word=%h", $time, rsp.list_word);
				errors++;
			end else begin
				want = expect_q.pop_front();
				if (want.word !== rsp.list_word || want.count !== rsp.member_count ||
					want.status !== rsp.status || want.last !== rsp.last_flag) begin
					$display("%0t: expected w=%h c=%h s=%b l=%b got w=%h c=%h s=%b l=%b",
						$time, want.word, want.count, want.status, want.last,
						rsp.list_word, rsp.member_count, rsp.status, rsp.last_flag);
					errors++;
				end
			end
		end
		if (cycles > 3000000) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		req.valid = 1'b0;
		req.opcode = OP_ADD;
		req.rank_value = '0;
		rsp.ready = 1'b0;
		for (int i = 0; i < STORE_WORDS; i++) list_mem[i] = '0;
		desc_total = 0;
		used_words = 1;
		held = '0;
		rank_cursor = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_empty_and_extremes();
		test_strided_runs();
		test_max_depth();
		test_overflow_stall();
		test_random();
		drain();
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/sdrc_pkg.sv
rtl/sdrc_req_if.sv
rtl/sdrc_rsp_if.sv
rtl/sdrc_front.sv
rtl/sdrc_back.sv
rtl/stride_descriptor_rank_compressor.sv
sim/stride_descriptor_rank_compressor_tb.sv
